// ===== rtl/pltc_pkg.sv =====
// Package for the prefix logic tautology checker.
// Holds shared types, character and status codes, truth patterns and the operator function.
// No dependencies.
package pltc_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned VAL_W       = 32;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_P = 8'h70;
  localparam logic [7:0] CH_T = 8'h74;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  typedef enum logic [2:0] {
    OP_AND = 3'd0,
    OP_OR  = 3'd1,
    OP_NOT = 3'd2,
    OP_IMP = 3'd3,
    OP_EQV = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    TK_NONE = 2'd0,
    TK_OP   = 2'd1,
    TK_VAR  = 2'd2
  } tok_kind_e;

  // One classified character: operator code or variable index in arg
  typedef struct packed {
    tok_kind_e   kind;
    logic [2:0]  arg;
    logic        last;
  } tok_t;

  typedef struct packed {
    op_e               code;
    logic              have_left;
    logic [VAL_W-1:0]  left;
  } stk_ent_t;

  typedef struct packed {
    logic        is_taut;
    logic [1:0]  status;
  } res_t;

  // Bit k of variable i is bit i of k
  function automatic logic [VAL_W-1:0] var_pattern(input logic [2:0] idx);
    logic [VAL_W-1:0] pat;
    unique case (idx)
      3'd0:    pat = 32'hAAAA_AAAA;
      3'd1:    pat = 32'hCCCC_CCCC;
      3'd2:    pat = 32'hF0F0_F0F0;
      3'd3:    pat = 32'hFF00_FF00;
      3'd4:    pat = 32'hFFFF_0000;
      default: pat = '0;
    endcase
    return pat;
  endfunction

  function automatic logic [VAL_W-1:0] apply_op(input op_e code,
                                                 input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] r;
    case (code)
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_IMP:  r = ~a | b;
      default: r = ~(a ^ b);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pltc_front.sv =====
// Front end: classifies characters into tokens and queues them for the back end.
// Depends on pltc_pkg.
module pltc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  input  logic             push,
  output logic             full,
  output logic             tok_valid_o,
  output pltc_pkg::tok_t   tok_o,
  input  logic             tok_pop_i
);
  import pltc_pkg::*;

  tok_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  tok_t              cls;
  logic              enq, deq;

  always_comb begin
    cls.last = last_char_i;
    cls.arg  = '0;
    cls.kind = TK_NONE;
    unique case (char_code_i)
      CH_K: begin cls.kind = TK_OP; cls.arg = OP_AND; end
      CH_A: begin cls.kind = TK_OP; cls.arg = OP_OR;  end
      CH_N: begin cls.kind = TK_OP; cls.arg = OP_NOT; end
      CH_C: begin cls.kind = TK_OP; cls.arg = OP_IMP; end
      CH_E: begin cls.kind = TK_OP; cls.arg = OP_EQV; end
      default: begin
        if (char_code_i >= CH_P && char_code_i <= CH_T) begin
          cls.kind = TK_VAR;
          cls.arg  = 3'(char_code_i - CH_P);
        end
      end
    endcase
  end

  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = q_mem[rd_ptr_q];

  // Drop ignored characters unless they close the expression
  assign enq = push && !full && (cls.kind != TK_NONE || cls.last);
  assign deq = tok_pop_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(enq) - QCNT_W'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QDEPTH))
    else $error("token queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> tok_valid_o)
    else $error("token queue full yet offers no token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_o && !tok_pop_i |=> tok_valid_o && tok_o == $past(tok_o))
    else $error("waiting token changed before it was taken");

endmodule

// ===== rtl/pltc_back.sv =====
// Back end: runs tokens against the operator stack held in a single-port memory.
// Depends on pltc_pkg.
module pltc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  pltc_pkg::tok_t   tok_i,
  output logic             tok_pop_o,
  output logic             res_valid_o,
  output pltc_pkg::res_t   res_o,
  input  logic             res_ready_i
);
  import pltc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              done_q, done_d;
  logic [VAL_W-1:0]  final_q, final_d;
  logic              ovf_q, ovf_d;
  logic              any_q, any_d;
  logic              last_q, last_d;
  logic [VAL_W-1:0]  x_q, x_d;

  stk_ent_t          stk_mem [STACK_DEPTH];
  stk_ent_t          rd_q;
  stk_ent_t          wr_data;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr, top_idx;
  logic [VAL_W-1:0]  nx;

  assign top_idx = IDX_W'(fill_q - FILL_W'(1));

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    done_d    = done_q;
    final_d   = final_q;
    ovf_d     = ovf_q;
    any_d     = any_q;
    last_d    = last_q;
    x_d       = x_q;
    wr_en     = 1'b0;
    wr_addr   = top_idx;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = top_idx;
    tok_pop_o = 1'b0;
    res_valid_o = 1'b0;
    nx        = (rd_q.code == OP_NOT) ? ~x_q : apply_op(rd_q.code, rd_q.left, x_q);

    unique case (state_q)
      S_IDLE: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          last_d    = tok_i.last;
          state_d   = S_DONE;
          if (!done_q) begin
            case (tok_i.kind)
              TK_OP: begin
                any_d = 1'b1;
                if (fill_q == FILL_W'(STACK_DEPTH)) begin
                  ovf_d = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(fill_q);
                  wr_data = '{code: op_e'(tok_i.arg), have_left: 1'b0, left: '0};
                  fill_d  = fill_q + FILL_W'(1);
                end
              end
              TK_VAR: begin
                any_d = 1'b1;
                x_d   = var_pattern(tok_i.arg);
                if (fill_q == '0) begin
                  done_d  = 1'b1;
                  final_d = var_pattern(tok_i.arg);
                end else begin
                  rd_en   = 1'b1;
                  state_d = S_EVAL;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_EVAL: begin
        if (rd_q.code != OP_NOT && !rd_q.have_left) begin
          // Park the operand as the left side of the waiting operator
          wr_en   = 1'b1;
          wr_data = '{code: rd_q.code, have_left: 1'b1, left: x_q};
          state_d = S_DONE;
        end else begin
          fill_d = fill_q - FILL_W'(1);
          x_d    = nx;
          if (fill_q == FILL_W'(1)) begin
            done_d  = 1'b1;
            final_d = nx;
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(fill_q - FILL_W'(2));
          end
        end
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          res_valid_o = 1'b1;
          if (res_ready_i) begin
            fill_d  = '0;
            done_d  = 1'b0;
            final_d = '1;
            ovf_d   = 1'b0;
            any_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (ovf_q) begin
      res_o = '{is_taut: 1'b0, status: ST_OVERFLOW};
    end else if (!any_q) begin
      res_o = '{is_taut: 1'b1, status: ST_OK};
    end else if (!done_q) begin
      res_o = '{is_taut: 1'b0, status: ST_INCOMPLETE};
    end else begin
      res_o = '{is_taut: (final_q == '1), status: ST_OK};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
      final_q <= '1;
      ovf_q   <= 1'b0;
      any_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      final_q <= final_d;
      ovf_q   <= ovf_d;
      any_q   <= any_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= stk_mem[rd_addr];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> fill_q != '0)
    else $error("reduction step with empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && tok_valid_i && tok_i.kind == TK_VAR && !done_q && fill_q == '0)
    |=> done_q)
    else $error("operand on empty stack did not complete the expression");

endmodule

// ===== rtl/prefix_logic_tautology_checker.sv =====
// Top level of the prefix logic tautology checker.
// Depends on pltc_pkg, pltc_front and pltc_back.
//
// Feed one character per word, last_char_i set on the final character of an
// expression; one result word (is_tautology_o, status_o) appears per expression.
// Variables p..t are evaluated over all 32 assignments at once; K, A, N, C, E are
// prefix and, or, not, implication and equivalence; other characters are ignored,
// as is anything after the first complete expression. An empty expression is a
// tautology. Status 1 means the expression was incomplete, status 2 that the
// 64-entry operator stack overflowed (this wins); in both cases is_tautology_o is 0.
// Timing: the front end takes one character per cycle, unless full is set, into a
// four-word token queue and drops ignored characters there, so they cost nothing
// further. The back end pops each token in its idle state and passes through its
// done state afterwards. An operand on a non-empty stack enters the evaluate state
// and reduces one stacked operator per step until it closes the expression or parks
// as the left side of a waiting operator: every reduction step is one read of the
// single-port stack memory, whose read is registered. The result word is held in
// an output register until popped, while input words keep flowing into the queue
// as long as it has room.
module prefix_logic_tautology_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  input  logic        push,
  output logic        full,
  output logic        is_tautology_o,
  output logic [1:0]  status_o,
  output logic        empty,
  input  logic        pop
);
  import pltc_pkg::*;

  tok_t  tok;
  logic  tok_valid, tok_pop;
  res_t  res;
  logic  res_valid, res_ready;
  logic  out_valid_q;
  res_t  out_q;

  // Classify and queue incoming characters
  pltc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .push        (push),
    .full        (full),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // Run tokens against the operator stack
  pltc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Hold the result word until popped; a pop frees the slot in the same cycle
  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign empty          = !out_valid_q;
  assign is_tautology_o = out_q.is_taut;
  assign status_o       = out_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_o != ST_OK |-> !is_tautology_o)
    else $error("failed status reported as tautology");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_o == ST_OK || status_o == ST_INCOMPLETE ||
                     status_o == ST_OVERFLOW))
    else $error("unknown status code on result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q && $stable(out_q))
    else $error("waiting result word changed before it was popped");

endmodule
